// ===== sv/ifd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 forwarding decision package
// Shared constants, codes, status records and helper functions.
// ----------------------------------------------------------------------------
package ifd_pkg;

    localparam int ROUTE_ENTRIES_DEF = 16;
    localparam int ACC_W = 20;

    localparam logic [15:0] MIN_FRAME_LEN = 16'd34;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] TTL_LAST = 8'd1;
    localparam logic [7:0] TTL_STEP = 8'd1;

    typedef enum logic [2:0] {
        VERD_FORWARD      = 3'd0,
        VERD_LOCAL_ICMP   = 3'd1,
        VERD_PORT_UNREACH = 3'd2,
        VERD_TTL_EXPIRED  = 3'd3,
        VERD_BAD_CSUM     = 3'd4,
        VERD_SHORT        = 3'd5,
        VERD_NO_ROUTE     = 3'd6,
        VERD_LOADED       = 3'd7
    } verdict_t;

    typedef enum logic [1:0] {
        CFG_IF_ONE   = 2'd0,
        CFG_IF_TWO   = 2'd1,
        CFG_IF_THREE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_LAUNCH,
        TOP_WAIT,
        TOP_DONE
    } top_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ACC,
        CS_CHK,
        CS_NEW
    } csum_state_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [1:0]  port;
    } route_entry_t;

    typedef struct packed {
        logic       done;
        logic       found;
        logic [1:0] port;
    } lpm_status_t;

    typedef struct packed {
        logic        done;
        logic [15:0] calc_sum;
        logic [15:0] new_sum;
    } csum_status_t;

    // Number of one bits in a 32-bit mask, counted a byte at a time.
    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [5:0] total;
        logic [3:0] part;
        total = '0;
        for (int b = 0; b < 4; b++) begin
            part = '0;
            for (int k = 0; k < 8; k++) begin
                part = part + {3'b000, v[8 * b + k]};
            end
            total = total + {2'b00, part};
        end
        return total;
    endfunction

    // End-around carry folding and complement of a partial header sum.
    function automatic logic [15:0] csum_fold(input logic [ACC_W-1:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, s[15:0]} + 17'(s[ACC_W-1:16]);
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return ~f2[15:0];
    endfunction

endpackage

// ===== sv/ifd_route_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table
// Entry memory with one write port and one registered read port; the
// in-use bits live in flip-flops that reset clears.
// ----------------------------------------------------------------------------
module ifd_route_table #(
    parameter int ROUTE_ENTRIES = ifd_pkg::ROUTE_ENTRIES_DEF,
    parameter int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ifd_pkg::route_entry_t wr_entry,
    input  logic                 wr_valid,
    input  logic [IDX_W-1:0]     rd_addr,
    output ifd_pkg::route_entry_t rd_entry,
    output logic                 rd_valid
);
    import ifd_pkg::*;

    route_entry_t             route_mem [ROUTE_ENTRIES];
    route_entry_t             rd_entry_reg;
    logic [ROUTE_ENTRIES-1:0] valid_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            route_mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= route_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= wr_valid;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== sv/ifd_lpm_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest prefix match scanner
// Walks the route table one entry per cycle and keeps the best match.
// ----------------------------------------------------------------------------
module ifd_lpm_scan #(
    parameter int ROUTE_ENTRIES = ifd_pkg::ROUTE_ENTRIES_DEF,
    parameter int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           dest,
    output logic [IDX_W-1:0]      rd_addr,
    input  ifd_pkg::route_entry_t rd_entry,
    input  logic                  rd_valid,
    output ifd_pkg::lpm_status_t  status
);
    import ifd_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

    logic             issue_reg,    issue_next;
    logic [IDX_W-1:0] addr_reg,     addr_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_last_reg,  s1_last_next;
    logic             s2_valid_reg, s2_valid_next;
    logic             s2_last_reg,  s2_last_next;
    logic             s2_match_reg, s2_match_next;
    logic [5:0]       s2_len_reg;
    logic [1:0]       s2_port_reg;
    logic             found_reg,    found_next;
    logic [5:0]       best_len_reg, best_len_next;
    logic [1:0]       best_port_reg, best_port_next;
    logic             done_reg,     done_next;
    logic             take_best;

    always_comb
    begin
        issue_next    = issue_reg;
        addr_next     = addr_reg;
        if (start)
        begin
            issue_next = 1'b1;
            addr_next  = '0;
        end
        else if (issue_reg)
        begin
            addr_next = addr_reg + 1'b1;
            if (addr_reg == LAST_IDX)
            begin
                issue_next = 1'b0;
            end
        end

        s1_valid_next = issue_reg && !start;
        s1_last_next  = issue_reg && (addr_reg == LAST_IDX);
        s2_valid_next = s1_valid_reg;
        s2_last_next  = s1_last_reg;
        s2_match_next = rd_valid && (((dest ^ rd_entry.prefix) & rd_entry.mask) == 32'd0);

        take_best = s2_valid_reg && s2_match_reg && (!found_reg || (s2_len_reg > best_len_reg));

        found_next     = found_reg;
        best_len_next  = best_len_reg;
        best_port_next = best_port_reg;
        done_next      = done_reg;
        if (start)
        begin
            found_next = 1'b0;
            done_next  = 1'b0;
        end
        else
        begin
            if (take_best)
            begin
                found_next     = 1'b1;
                best_len_next  = s2_len_reg;
                best_port_next = s2_port_reg;
            end
            if (s2_valid_reg && s2_last_reg)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            addr_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            s2_match_reg <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            issue_reg    <= issue_next;
            addr_reg     <= addr_next;
            s1_valid_reg <= s1_valid_next;
            s1_last_reg  <= s1_last_next;
            s2_valid_reg <= s2_valid_next;
            s2_last_reg  <= s2_last_next;
            s2_match_reg <= s2_match_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_len_reg    <= popcount32(rd_entry.mask);
        s2_port_reg   <= rd_entry.port;
        best_len_reg  <= best_len_next;
        best_port_reg <= best_port_next;
    end

    assign rd_addr      = addr_reg;
    assign status.done  = done_reg;
    assign status.found = found_reg;
    assign status.port  = best_port_reg;

endmodule

// ===== sv/ifd_csum_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header checksum unit
// One 20-bit adder sums the header words a word per cycle, then folds the
// sum with the original and with the decremented time to live word.
// ----------------------------------------------------------------------------
module ifd_csum_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           hdr_word_a,
    input  logic [63:0]           hdr_word_b,
    input  logic [31:0]           hdr_dest,
    output ifd_pkg::csum_status_t status
);
    import ifd_pkg::*;

    csum_state_t      state_reg, state_next;
    logic [2:0]       cnt_reg,   cnt_next;
    logic [ACC_W-1:0] acc_reg,   acc_next;
    logic [15:0]      calc_reg,  calc_next;
    logic [15:0]      new_reg,   new_next;
    logic             done_reg,  done_next;
    logic [15:0]      add_word;
    logic [ACC_W-1:0] add_sum;
    logic [7:0]       ttl_dec;

    assign ttl_dec = hdr_word_b[63:56] - TTL_STEP;
    assign add_sum = acc_reg + ACC_W'(add_word);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    state_next = CS_ACC;
                end
            end
            CS_ACC:
            begin
                if (cnt_reg == 3'd7)
                begin
                    state_next = CS_CHK;
                end
            end
            CS_CHK:  state_next = CS_NEW;
            CS_NEW:  state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        add_word = 16'd0;
        case (state_reg)
            CS_ACC:
            begin
                case (cnt_reg)
                    3'd0:    add_word = hdr_word_a[63:48];
                    3'd1:    add_word = hdr_word_a[47:32];
                    3'd2:    add_word = hdr_word_a[31:16];
                    3'd3:    add_word = hdr_word_a[15:0];
                    3'd4:    add_word = hdr_word_b[31:16];
                    3'd5:    add_word = hdr_word_b[15:0];
                    3'd6:    add_word = hdr_dest[31:16];
                    3'd7:    add_word = hdr_dest[15:0];
                    default: add_word = 16'd0;
                endcase
            end
            CS_CHK:  add_word = hdr_word_b[63:48];
            CS_NEW:  add_word = {ttl_dec, hdr_word_b[55:48]};
            default: add_word = 16'd0;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        calc_next = calc_reg;
        new_next  = new_reg;
        done_next = done_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    cnt_next  = '0;
                    acc_next  = '0;
                    done_next = 1'b0;
                end
            end
            CS_ACC:
            begin
                cnt_next = cnt_reg + 3'd1;
                acc_next = add_sum;
            end
            CS_CHK:  calc_next = csum_fold(add_sum);
            CS_NEW:
            begin
                new_next  = csum_fold(add_sum);
                done_next = 1'b1;
            end
            default: done_next = done_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        calc_reg <= calc_next;
        new_reg  <= new_next;
    end

    assign status.done     = done_reg;
    assign status.calc_sum = calc_reg;
    assign status.new_sum  = new_reg;

endmodule

// ===== sv/ipv4_forwarding_decision_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 forwarding decision unit
// Loads route table entries or judges IPv4 headers: short frame, checksum,
// local delivery, expired time to live, longest prefix match and forward.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  in      | input     | in_valid / in_stall   | action, frame_len, header, route
//  out     | output    | out_valid / out_stall | verdict, out_port, new_ttl, ...
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A header item waits until the route table scan, at one entry per cycle, and
// the checksum unit are both done; a load item goes straight to the done state.
// The block takes one item at a time and holds in_stall high while it works.
// A result waits in the output register while out_stall is high; the block
// then holds its next result until the register is free.
// Reset clears the interface addresses and all route entry in-use bits.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision_unit #(
    parameter int ROUTE_ENTRIES = ifd_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] frame_len,
    input  logic [63:0] hdr_word_a,
    input  logic [63:0] hdr_word_b,
    input  logic [31:0] hdr_dest,
    input  logic [3:0]  route_slot,
    input  logic [31:0] route_prefix,
    input  logic [31:0] route_mask,
    input  logic [1:0]  route_port,
    input  logic        route_valid,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  verdict,
    output logic [1:0]  out_port,
    output logic [7:0]  new_ttl,
    output logic [15:0] new_checksum
);
    import ifd_pkg::*;

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam logic [8:0] SLOT_LIMIT = 9'(ROUTE_ENTRIES);

    top_state_t   state_reg, state_next;
    logic [31:0]  if_one_reg;
    logic [31:0]  if_two_reg;
    logic [31:0]  if_three_reg;
    logic         act_reg;
    logic [15:0]  flen_reg;
    logic [63:0]  hdr_a_reg;
    logic [63:0]  hdr_b_reg;
    logic [31:0]  dest_reg;
    logic         out_valid_reg, out_valid_next;
    logic [2:0]   verdict_reg;
    logic [1:0]   out_port_reg;
    logic [7:0]   new_ttl_reg;
    logic [15:0]  new_csum_reg;

    logic         accept;
    logic         start;
    logic         out_load;
    logic [8:0]   slot_ext;
    logic         tbl_wr_en;
    route_entry_t tbl_wr_entry;
    logic [IDX_W-1:0] tbl_rd_addr;
    route_entry_t tbl_rd_entry;
    logic         tbl_rd_valid;
    lpm_status_t  lpm_st;
    csum_status_t csum_st;

    verdict_t     res_verdict;
    logic [1:0]   res_port;
    logic [7:0]   res_ttl;
    logic [15:0]  res_csum;
    logic         dest_local;

    assign accept   = in_valid && !in_stall;
    assign slot_ext = {5'd0, route_slot};
    assign tbl_wr_en = accept && action && (slot_ext < SLOT_LIMIT);
    assign tbl_wr_entry.prefix = route_prefix;
    assign tbl_wr_entry.mask   = route_mask;
    assign tbl_wr_entry.port   = route_port;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE:
            begin
                if (accept)
                begin
                    state_next = action ? TOP_DONE : TOP_LAUNCH;
                end
            end
            TOP_LAUNCH: state_next = TOP_WAIT;
            TOP_WAIT:
            begin
                if (lpm_st.done && csum_st.done)
                begin
                    state_next = TOP_DONE;
                end
            end
            TOP_DONE:
            begin
                if (out_load)
                begin
                    state_next = TOP_IDLE;
                end
            end
            default: state_next = TOP_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        start    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            TOP_IDLE:   in_stall = 1'b0;
            TOP_LAUNCH: start = 1'b1;
            TOP_WAIT:   start = 1'b0;
            TOP_DONE:   out_load = !out_valid_reg || !out_stall;
            default:    in_stall = 1'b1;
        endcase
    end

    assign dest_local = (dest_reg == if_one_reg) || (dest_reg == if_two_reg) ||
                        (dest_reg == if_three_reg);

    always_comb
    begin
        res_verdict = VERD_LOADED;
        res_port    = 2'd0;
        res_ttl     = 8'd0;
        res_csum    = 16'd0;
        if (!act_reg)
        begin
            if (flen_reg < MIN_FRAME_LEN)
            begin
                res_verdict = VERD_SHORT;
            end
            else if (csum_st.calc_sum != hdr_b_reg[47:32])
            begin
                res_verdict = VERD_BAD_CSUM;
            end
            else if (dest_local)
            begin
                res_verdict = (hdr_b_reg[55:48] == PROTO_ICMP) ? VERD_LOCAL_ICMP
                                                               : VERD_PORT_UNREACH;
            end
            else if (hdr_b_reg[63:56] <= TTL_LAST)
            begin
                res_verdict = VERD_TTL_EXPIRED;
            end
            else if (!lpm_st.found)
            begin
                res_verdict = VERD_NO_ROUTE;
            end
            else
            begin
                res_verdict = VERD_FORWARD;
                res_port    = lpm_st.port;
                res_ttl     = hdr_b_reg[63:56] - TTL_STEP;
                res_csum    = csum_st.new_sum;
            end
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            out_valid_reg <= 1'b0;
            if_one_reg    <= '0;
            if_two_reg    <= '0;
            if_three_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IF_ONE:   if_one_reg   <= cfg_data;
                    CFG_IF_TWO:   if_two_reg   <= cfg_data;
                    CFG_IF_THREE: if_three_reg <= cfg_data;
                    default:      if_one_reg   <= if_one_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            flen_reg  <= frame_len;
            hdr_a_reg <= hdr_word_a;
            hdr_b_reg <= hdr_word_b;
            dest_reg  <= hdr_dest;
        end
        if (out_load)
        begin
            verdict_reg  <= res_verdict;
            out_port_reg <= res_port;
            new_ttl_reg  <= res_ttl;
            new_csum_reg <= res_csum;
        end
    end

    ifd_route_table #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr_en),
        .wr_addr  (slot_ext[IDX_W-1:0]),
        .wr_entry (tbl_wr_entry),
        .wr_valid (route_valid),
        .rd_addr  (tbl_rd_addr),
        .rd_entry (tbl_rd_entry),
        .rd_valid (tbl_rd_valid)
    );

    ifd_lpm_scan #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dest     (dest_reg),
        .rd_addr  (tbl_rd_addr),
        .rd_entry (tbl_rd_entry),
        .rd_valid (tbl_rd_valid),
        .status   (lpm_st)
    );

    ifd_csum_unit u_csum (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .hdr_word_a (hdr_a_reg),
        .hdr_word_b (hdr_b_reg),
        .hdr_dest   (dest_reg),
        .status     (csum_st)
    );

    assign out_valid    = out_valid_reg;
    assign verdict      = verdict_reg;
    assign out_port     = out_port_reg;
    assign new_ttl      = new_ttl_reg;
    assign new_checksum = new_csum_reg;

endmodule

// ===== sv/ifd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 forwarding decision checker
// Port-level properties of the decision unit, attached by bind.
// ----------------------------------------------------------------------------
module ifd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  verdict,
    input logic [1:0]  out_port,
    input logic [7:0]  new_ttl,
    input logic [15:0] new_checksum
);
    import ifd_pkg::*;

    // The unit works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while previous item still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) &&
        $stable(out_port) && $stable(new_ttl) && $stable(new_checksum))
        else $error("stalled result item changed");

    a_zero_unless_forward: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict != VERD_FORWARD) |->
        (out_port == 2'd0) && (new_ttl == 8'd0) && (new_checksum == 16'd0))
        else $error("non-forward item carries forwarding fields");

    // A forwarded header had a time to live of at least two.
    a_forward_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == VERD_FORWARD) |-> (new_ttl != 8'd0))
        else $error("forwarded item with expired time to live");

endmodule

bind ipv4_forwarding_decision_unit ifd_checker u_ifd_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 forwarding decision unit testbench
// Drives route loads and IPv4 headers through the valid/stall input channel,
// predicts each verdict with a behavioral route table and checksum model, and
// compares every result item field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    import ifd_pkg::*;

    localparam int TABLE_SLOTS    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 160;
    localparam int END_PAUSE      = 40;

    typedef struct packed {
        logic        action;
        logic [15:0] frame_len;
        logic [63:0] word_a;
        logic [63:0] word_b;
        logic [31:0] dest;
        logic [3:0]  slot;
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [1:0]  port;
        logic        in_use;
    } fwd_item_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [1:0]  port;
        logic [7:0]  ttl;
        logic [15:0] csum;
    } decision_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic [15:0] frame_len = 16'd0;
    logic [63:0] hdr_word_a = 64'd0;
    logic [63:0] hdr_word_b = 64'd0;
    logic [31:0] hdr_dest = 32'd0;
    logic [3:0]  route_slot = 4'd0;
    logic [31:0] route_prefix = 32'd0;
    logic [31:0] route_mask = 32'd0;
    logic [1:0]  route_port = 2'd0;
    logic        route_valid = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  verdict;
    logic [1:0]  out_port;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;

    fwd_item_t   items_to_send[$];
    decision_t   pending_decisions[$];
    fwd_item_t   cur_item;

    logic [31:0] if_addr[3];
    logic [31:0] rt_prefix[TABLE_SLOTS];
    logic [31:0] rt_mask[TABLE_SLOTS];
    logic [1:0]  rt_port[TABLE_SLOTS];
    logic        rt_valid[TABLE_SLOTS];

    logic [31:0] plan_prefix[TABLE_SLOTS];
    logic [31:0] plan_mask[TABLE_SLOTS];

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned verdict_seen[8];
    int unsigned phases_run = 0;

    ipv4_forwarding_decision_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .frame_len    (frame_len),
        .hdr_word_a   (hdr_word_a),
        .hdr_word_b   (hdr_word_b),
        .hdr_dest     (hdr_dest),
        .route_slot   (route_slot),
        .route_prefix (route_prefix),
        .route_mask   (route_mask),
        .route_port   (route_port),
        .route_valid  (route_valid),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .verdict      (verdict),
        .out_port     (out_port),
        .new_ttl      (new_ttl),
        .new_checksum (new_checksum)
    );

    always #6 clk = ~clk;

    function automatic logic [15:0] header_checksum(logic [63:0] a, logic [63:0] b,
                                                    logic [31:0] d);
        logic [31:0] s;
        s = {16'd0, a[63:48]} + {16'd0, a[47:32]} + {16'd0, a[31:16]} + {16'd0, a[15:0]};
        s = s + {16'd0, b[63:48]} + {16'd0, b[31:16]} + {16'd0, b[15:0]};
        s = s + {16'd0, d[31:16]} + {16'd0, d[15:0]};
        s = (s >> 16) + (s & 32'h0000_FFFF);
        s = s + (s >> 16);
        return ~s[15:0];
    endfunction

    function automatic logic [31:0] prefix_mask(int unsigned len);
        return (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies a load to the route table or decides the fate of one header.
    function automatic decision_t judge_item(fwd_item_t it);
        decision_t   d;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [7:0]  dec_ttl;
        bit          found;
        int unsigned best;
        int unsigned len;
        d = '0;
        ttl = it.word_b[63:56];
        proto = it.word_b[55:48];
        found = 0;
        best = 0;
        if (it.action) begin
            rt_prefix[it.slot] = it.prefix;
            rt_mask[it.slot] = it.mask;
            rt_port[it.slot] = it.port;
            rt_valid[it.slot] = it.in_use;
            d.verdict = VERD_LOADED;
        end
        else if (it.frame_len < MIN_FRAME_LEN) begin
            d.verdict = VERD_SHORT;
        end
        else if (header_checksum(it.word_a, it.word_b, it.dest) != it.word_b[47:32]) begin
            d.verdict = VERD_BAD_CSUM;
        end
        else if (it.dest == if_addr[0] || it.dest == if_addr[1] || it.dest == if_addr[2]) begin
            d.verdict = (proto == PROTO_ICMP) ? VERD_LOCAL_ICMP : VERD_PORT_UNREACH;
        end
        else if (ttl <= TTL_LAST) begin
            d.verdict = VERD_TTL_EXPIRED;
        end
        else begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (rt_valid[i] && ((it.dest ^ rt_prefix[i]) & rt_mask[i]) == 32'd0) begin
                    len = $countones(rt_mask[i]);
                    if (!found || len > best) begin
                        found = 1;
                        best = len;
                        d.port = rt_port[i];
                    end
                end
            end
            if (!found) begin
                d.verdict = VERD_NO_ROUTE;
            end
            else begin
                dec_ttl = ttl - TTL_STEP;
                d.verdict = VERD_FORWARD;
                d.ttl = dec_ttl;
                d.csum = header_checksum(it.word_a, {dec_ttl, it.word_b[55:0]}, it.dest);
            end
        end
        return d;
    endfunction

    function automatic fwd_item_t random_item();
        fwd_item_t it;
        it.action = 1'($urandom_range(0, 1));
        it.frame_len = 16'($urandom_range(0, 65535));
        it.word_a = {$urandom, $urandom};
        it.word_b = {$urandom, $urandom};
        it.dest = $urandom;
        it.slot = 4'($urandom_range(0, 15));
        it.prefix = $urandom;
        it.mask = $urandom;
        it.port = 2'($urandom_range(0, 3));
        it.in_use = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic void send_header(logic [15:0] flen, logic [63:0] a, logic [7:0] ttl,
                                        logic [7:0] proto, logic [31:0] src,
                                        logic [31:0] dest, bit corrupt);
        fwd_item_t   it;
        logic [15:0] sum;
        it = random_item();
        it.action = 1'b0;
        it.frame_len = flen;
        it.word_a = a;
        it.word_b = {ttl, proto, 16'd0, src};
        it.dest = dest;
        sum = header_checksum(a, it.word_b, dest);
        if (corrupt)
            sum = sum ^ 16'($urandom_range(1, 65535));
        it.word_b[47:32] = sum;
        items_to_send.push_back(it);
    endfunction

    function automatic void send_load(logic [3:0] slot, logic [31:0] pfx, logic [31:0] msk,
                                      logic [1:0] port, logic in_use);
        fwd_item_t it;
        it = random_item();
        it.action = 1'b1;
        it.slot = slot;
        it.prefix = pfx;
        it.mask = msk;
        it.port = port;
        it.in_use = in_use;
        plan_prefix[slot] = pfx;
        plan_mask[slot] = msk;
        items_to_send.push_back(it);
    endfunction

    task automatic write_if_addr(cfg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if_addr[idx] = value;
    endtask

    task automatic set_if_addrs(logic [31:0] one, logic [31:0] two, logic [31:0] three);
        write_if_addr(CFG_IF_ONE, one);
        write_if_addr(CFG_IF_TWO, two);
        write_if_addr(CFG_IF_THREE, three);
        @(negedge clk);
    endtask

    task automatic wait_all_done();
        @(negedge clk);
        while (items_to_send.size() != 0 || in_valid || pending_decisions.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        phases_run++;
    endtask

    function automatic logic [63:0] random_word_a();
        logic [63:0] a;
        a = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 80)
            a[63:56] = 8'h45;
        return a;
    endfunction

    function automatic void random_phase(int unsigned count);
        int unsigned r;
        int unsigned len;
        int unsigned s;
        logic [31:0] msk;
        logic [31:0] pfx;
        logic [31:0] dest;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [15:0] flen;
        fwd_item_t   it;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                s = $urandom_range(0, 99);
                len = (s < 10) ? 0 : (s < 15) ? $urandom_range(1, 7) : $urandom_range(8, 32);
                msk = ($urandom_range(0, 99) < 8) ? $urandom : prefix_mask(len);
                pfx = $urandom;
                if ($urandom_range(0, 99) < 70)
                    pfx = pfx & msk;
                send_load(4'($urandom_range(0, 15)), pfx, msk, 2'($urandom_range(0, 3)),
                          $urandom_range(0, 99) < 85);
            end
            else if (r < 24) begin
                it = random_item();
                it.action = 1'b0;
                items_to_send.push_back(it);
            end
            else begin
                s = $urandom_range(0, 99);
                if (s < 45) begin
                    len = $urandom_range(0, 15);
                    dest = (plan_prefix[len] & plan_mask[len]) | ($urandom & ~plan_mask[len]);
                end
                else if (s < 60)
                    dest = if_addr[$urandom_range(0, 2)];
                else if (s < 70)
                    dest = if_addr[$urandom_range(0, 2)] ^ (32'd1 << $urandom_range(0, 31));
                else
                    dest = $urandom;
                s = $urandom_range(0, 99);
                ttl = (s < 10) ? 8'($urandom_range(0, 1)) : (s < 15) ? 8'd2 :
                      (s < 18) ? 8'd255 : 8'($urandom_range(2, 255));
                proto = ($urandom_range(0, 99) < 30) ? PROTO_ICMP : 8'($urandom_range(0, 255));
                s = $urandom_range(0, 99);
                flen = (s < 8) ? 16'($urandom_range(0, 33)) : (s < 10) ? MIN_FRAME_LEN :
                       (s < 12) ? 16'hFFFF : (s < 17) ? 16'($urandom_range(0, 65535)) :
                       16'($urandom_range(34, 65535));
                send_header(flen, random_word_a(), ttl, proto, $urandom, dest,
                            $urandom_range(0, 99) < 8);
            end
        end
    endfunction

    always @(posedge clk) begin
        if (calm_left != 0)
            calm_left <= calm_left - 1;
        else if ($urandom_range(0, 199) == 0)
            calm_left <= $urandom_range(60, 200);
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else begin
            if (in_valid && !in_stall)
                pending_decisions.push_back(judge_item(cur_item));
            if (in_valid && in_stall) begin
            end
            else if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (items_to_send.size() != 0) begin
                cur_item = items_to_send.pop_front();
                action <= cur_item.action;
                frame_len <= cur_item.frame_len;
                hdr_word_a <= cur_item.word_a;
                hdr_word_b <= cur_item.word_b;
                hdr_dest <= cur_item.dest;
                route_slot <= cur_item.slot;
                route_prefix <= cur_item.prefix;
                route_mask <= cur_item.mask;
                route_port <= cur_item.port;
                route_valid <= cur_item.in_use;
                in_valid <= 1'b1;
                gap_left <= (calm_left != 0) ? 0 : idle_len();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        decision_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else begin
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else begin
                out_stall <= 1'b0;
                stall_left <= (calm_left != 0) ? 0 : idle_len();
            end
            if (out_valid && !out_stall) begin
                if (pending_decisions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result item: verdict %0d port %0d ttl %0d csum %04h",
                                 verdict, out_port, new_ttl, new_checksum);
                end
                else begin
                    want = pending_decisions.pop_front();
                    results_checked++;
                    verdict_seen[want.verdict]++;
                    if (verdict !== want.verdict || out_port !== want.port ||
                        new_ttl !== want.ttl || new_checksum !== want.csum) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch at %0t: expected verdict %0d port %0d ttl %0d ",
                                      "csum %04h, got verdict %0d port %0d ttl %0d csum %04h"},
                                     $realtime, want.verdict, want.port, want.ttl, want.csum,
                                     verdict, out_port, new_ttl, new_checksum);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            rt_prefix[i] = '0;
            rt_mask[i] = '0;
            rt_port[i] = '0;
            rt_valid[i] = 1'b0;
            plan_prefix[i] = '0;
            plan_mask[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            if_addr[i] = '0;
        for (int i = 0; i < 8; i++)
            verdict_seen[i] = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty table, short and corrupt frames, prefix lengths,
        // ties, expiry, local delivery ahead of expiry, route removal.
        set_if_addrs(32'hC0A8_0101, 32'hAC10_0001, 32'h0AFF_FFFE);
        send_header(16'd60, random_word_a(), 8'd64, 8'd6, $urandom, 32'h0808_0808, 0);
        send_header(16'd0, random_word_a(), 8'd64, 8'd6, $urandom, 32'h0808_0808, 0);
        send_header(16'd33, random_word_a(), 8'd64, 8'd6, $urandom, 32'h0808_0808, 0);
        send_header(MIN_FRAME_LEN, random_word_a(), 8'd64, 8'd6, $urandom, 32'h0808_0808, 1);
        send_load(4'd0, 32'h0000_0000, prefix_mask(0), 2'd1, 1'b1);
        send_load(4'd1, 32'h0A00_0000, prefix_mask(8), 2'd2, 1'b1);
        send_load(4'd2, 32'h0A01_0000, prefix_mask(16), 2'd3, 1'b1);
        send_load(4'd4, 32'h0A01_0000, prefix_mask(16), 2'd0, 1'b1);
        send_load(4'd15, 32'h0A01_0200, prefix_mask(24), 2'd2, 1'b1);
        send_load(4'd3, 32'h0A01_0203, prefix_mask(32), 2'd1, 1'b1);
        send_header(16'd98, random_word_a(), 8'd64, 8'd6, $urandom, 32'h0A01_0203, 0);
        send_header(16'd98, random_word_a(), 8'd64, 8'd6, $urandom, 32'h0A01_0204, 0);
        send_header(16'd98, random_word_a(), 8'd64, 8'd17, $urandom, 32'h0A01_FF01, 0);
        send_header(16'd98, random_word_a(), 8'd64, PROTO_ICMP, $urandom, 32'h0A7F_0001, 0);
        send_header(16'hFFFF, random_word_a(), 8'd2, 8'd6, $urandom, 32'h0808_0808, 0);
        send_header(16'd98, random_word_a(), 8'd255, 8'd6, $urandom, 32'h0808_0808, 0);
        send_header(16'd98, random_word_a(), 8'd0, 8'd6, $urandom, 32'h0808_0808, 0);
        send_header(16'd98, random_word_a(), 8'd1, 8'd6, $urandom, 32'h0808_0808, 0);
        send_header(16'd98, random_word_a(), 8'd64, PROTO_ICMP, $urandom, 32'hC0A8_0101, 0);
        send_header(16'd98, random_word_a(), 8'd64, 8'd17, $urandom, 32'hAC10_0001, 0);
        send_header(16'd98, random_word_a(), 8'd0, PROTO_ICMP, $urandom, 32'h0AFF_FFFE, 0);
        send_header(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 0);
        send_load(4'd0, 32'h0000_0000, prefix_mask(0), 2'd1, 1'b0);
        send_header(16'd98, random_word_a(), 8'd64, 8'd6, $urandom, 32'h0808_0808, 0);
        send_header(16'd34, 64'd0, 8'd64, 8'd0, 32'd0, 32'd0, 0);
        wait_all_done();

        set_if_addrs(32'd0, 32'd0, 32'd0);
        random_phase(PHASE_ITEMS);
        wait_all_done();

        set_if_addrs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);
        wait_all_done();

        set_if_addrs($urandom, $urandom, $urandom);
        random_phase(PHASE_ITEMS);
        wait_all_done();

        set_if_addrs($urandom, 32'hFFFF_FFFF, 32'd0);
        random_phase(PHASE_ITEMS);
        wait_all_done();

        repeat (END_PAUSE) @(posedge clk);

        $display("Checked %0d results over %0d phases; mismatches %0d.",
                 results_checked, phases_run, mismatches);
        $display({"Verdicts: forward %0d, local icmp %0d, unreachable %0d, expired %0d, ",
                  "bad checksum %0d, short %0d, no route %0d, loads %0d."},
                 verdict_seen[VERD_FORWARD], verdict_seen[VERD_LOCAL_ICMP],
                 verdict_seen[VERD_PORT_UNREACH], verdict_seen[VERD_TTL_EXPIRED],
                 verdict_seen[VERD_BAD_CSUM], verdict_seen[VERD_SHORT],
                 verdict_seen[VERD_NO_ROUTE], verdict_seen[VERD_LOADED]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== ipv4_forwarding_decision_unit.f =====
sv/ifd_pkg.sv
sv/ifd_route_table.sv
sv/ifd_lpm_scan.sv
sv/ifd_csum_unit.sv
sv/ipv4_forwarding_decision_unit.sv
sv/ifd_checker.sv
dv/tb_top.sv
